>>> hw/rtl/metric_poisson_hole_relaxation_macros.svh
// Assertion helpers for the hole relaxation block.
`ifndef METRIC_POISSON_HOLE_RELAXATION_MACROS_SVH
`define METRIC_POISSON_HOLE_RELAXATION_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define MPHR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check an implication in the cycle after the antecedent holds.
`define MPHR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/mphr_pkg.sv
package mphr_pkg;
  localparam int unsigned AddrW = 16;
  localparam logic [8:0] MaxDim = 9'd256;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRun   = 2'd1,
    OpRead  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegStep   = 2'd2,
    RegIter   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdRd,
    StFlag,
    StCtr,
    StNb,
    StMul1,
    StMul2,
    StWb,
    StNext,
    StResp
  } state_e;

  // Pixel store access request: one write or one read per cycle.
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  addr;
    logic [31:0]       wdata;
  } pix_req_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction
endpackage

>>> hw/rtl/metric_poisson_hole_relaxation.sv
// Poisson hole filling by in-place Gauss-Seidel relaxation.
// Input channel (in_valid_i/in_ready_o) carries one command beat: op 0 writes
// a pixel (value, metric, hole flag), op 1 runs iteration_count sweeps, op 2
// reads a pixel. Every beat yields exactly one result beat on the output
// channel (out_valid_o/out_ready_i) echoing the op.
// The pixel value lives in one single-port synchronous RAM, metric and hole
// flag in a second; both register their read data. A write or an unused op
// goes through StResp before its result is raised, a read through StRdRd
// and StResp; the next beat is taken only after the result has left.
// A run visits every active pixel per sweep: each one has its centre value
// and flag read, and a hole pixel also takes four neighbor reads, two
// multiply stages and a write back; a run is bound by the single pixel RAM
// port.
// One item is in work at a time; in_ready_o is low while an item is being
// processed or its result waits. A result is held in an output register until
// out_ready_i takes it. Reset returns registers to 256, 256, 0x4000, 100;
// the pixel RAMs are not cleared and need no clearing pass.
module metric_poisson_hole_relaxation import mphr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  row_i,
  input  logic signed [31:0] data_value_i,
  input  logic        is_hole_i,
  input  logic [15:0] metric_value_i,
  input  logic signed [31:0] init_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  done_op_o,
  output logic signed [31:0] read_value_o,
  output logic [31:0] max_update_o
);
  `include "metric_poisson_hole_relaxation_macros.svh"

  // Configuration registers.
  logic [8:0]  width_q, height_q;
  logic [15:0] step_q, iter_q;
  logic        cfg_we;
  reg_e        cfg_sel;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign cfg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      step_q   <= 16'd16384;
      iter_q   <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_sel)
        RegWidth:  width_q  <= pwdata[8:0];
        RegHeight: height_q <= pwdata[8:0];
        RegStep:   step_q   <= pwdata[15:0];
        RegIter:   iter_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RegWidth:  prdata = {23'd0, width_q};
      RegHeight: prdata = {23'd0, height_q};
      RegStep:   prdata = {16'd0, step_q};
      RegIter:   prdata = {16'd0, iter_q};
      default:   prdata = 32'd0;
    endcase
  end

  // Active dimensions clamped to 1..256, kept as last index 0..255.
  logic [7:0] wl, hl;
  assign wl = (width_q == 9'd0) ? 8'd0 : (width_q > MaxDim) ? 8'd255 : 8'(width_q - 9'd1);
  assign hl = (height_q == 9'd0) ? 8'd0 : (height_q > MaxDim) ? 8'd255 : 8'(height_q - 9'd1);

  // Control state.
  state_e      state_q, state_d;
  op_e         op_q;
  logic [7:0]  col_q, row_q;
  logic [31:0] wval_q;
  logic [16:0] wattr_q;
  logic [15:0] iter_cnt_q;
  logic [7:0]  a_q, b_q;          // row and column loop counters
  logic [2:0]  nb_q;              // neighbor read index
  logic signed [31:0] x_q;
  logic signed [34:0] sum_q;
  logic [15:0] metric_q;
  logic signed [31:0] t_q;
  logic signed [31:0] nv_q;
  logic [31:0] maxchg_q;
  logic        out_valid_q;
  logic [1:0]  done_op_q;
  logic [31:0] read_value_q, max_update_q;

  // Scan order for this sweep.
  logic       rx, ry;
  logic [7:0] r, c, rn, rs, cw, ce;
  assign rx = (iter_cnt_q[1:0] == 2'd1) || (iter_cnt_q[1:0] == 2'd2);
  assign ry = (iter_cnt_q[1:0] == 2'd1) || (iter_cnt_q[1:0] == 2'd3);
  assign r  = ry ? hl - a_q : a_q;
  assign c  = rx ? wl - b_q : b_q;
  assign rn = (r != 8'd0) ? r - 8'd1 : 8'd0;
  assign rs = (r != hl) ? r + 8'd1 : hl;
  assign cw = (c != 8'd0) ? c - 8'd1 : 8'd0;
  assign ce = (c != wl) ? c + 8'd1 : wl;

  // RAMs.
  pix_req_t    preq;
  logic [31:0] prd;
  logic        awe;
  logic [AddrW-1:0] aaddr;
  logic [16:0] ard;

  mphr_pixel_ram u_pix (.clk_i, .req_i(preq), .rdata_o(prd));
  mphr_attr_ram u_attr (.clk_i, .we_i(awe), .addr_i(aaddr), .wdata_i(wattr_q),
                        .rdata_o(ard));

  logic [AddrW-1:0] nb_addr;
  always_comb begin
    case (nb_q)
      3'd0:    nb_addr = {r, ce};
      3'd1:    nb_addr = {rs, c};
      3'd2:    nb_addr = {r, cw};
      default: nb_addr = {rn, c};
    endcase
  end

  // Datapath arithmetic: metric product and saturation in the first multiply
  // stage, step product and new value in the second.
  logic signed [34:0] lap;
  logic signed [63:0] prod1;
  logic signed [31:0] tsat;
  logic signed [63:0] prod2;
  logic signed [32:0] nsum;
  logic [31:0] chg;
  logic signed [32:0] diff;
  assign lap   = sum_q - 35'sd4 * 35'(x_q);
  assign prod1 = 64'(lap) * 64'($signed({1'b0, metric_q}));
  assign tsat  = sat32(prod1 >>> 8);
  assign prod2 = 64'(t_q) * 64'($signed({1'b0, step_q}));
  assign nsum  = 33'(x_q) + 33'(prod2 >>> 16);
  assign diff  = 33'(nv_q) - 33'(x_q);
  assign chg   = diff[32] ? 32'(-diff) : diff[31:0];

  logic in_acc, out_acc, last_px, last_iter;
  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;
  assign last_px = (a_q == hl) && (b_q == wl);
  assign last_iter = (iter_cnt_q == iter_q - 16'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc) begin
        case (op_e'(op_i))
          OpRun:   state_d = (iter_q == 16'd0) ? StResp : StFlag;
          OpRead:  state_d = StRdRd;
          default: state_d = StResp;
        endcase
      end
      StRdRd: state_d = StResp;
      StFlag: state_d = StCtr;
      StCtr:  state_d = ard[16] ? StNb : StNext;
      StNb:   state_d = (nb_q == 3'd4) ? StMul1 : StNb;
      StMul1: state_d = StMul2;
      StMul2: state_d = StWb;
      StWb:   state_d = StNext;
      StNext: state_d = (last_px && last_iter) ? StResp : StFlag;
      StResp: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // RAM requests.
  always_comb begin
    preq  = '{we: 1'b0, addr: {r, c}, wdata: nv_q};
    awe   = 1'b0;
    aaddr = {r, c};
    case (state_q)
      StIdle: begin
        preq.addr = {row_i, col_i};
        aaddr     = {row_i, col_i};
      end
      StRdRd: preq.addr = {row_q, col_q};
      StResp: if (op_q == OpWrite) begin
        preq  = '{we: 1'b1, addr: {row_q, col_q}, wdata: wval_q};
        awe   = 1'b1;
        aaddr = {row_q, col_q};
      end
      StNb:   preq.addr = nb_addr;
      StWb:   preq.we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      op_q        <= OpWrite;
    end else begin
      state_q <= state_d;
      if (in_acc) op_q <= op_e'(op_i);
      if (state_q == StResp) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (in_acc) begin
        col_q      <= col_i;
        row_q      <= row_i;
        wval_q     <= is_hole_i ? init_value_i : data_value_i;
        wattr_q    <= {is_hole_i, metric_value_i};
        iter_cnt_q <= 16'd0;
        a_q        <= 8'd0;
        b_q        <= 8'd0;
        maxchg_q   <= 32'd0;
      end
      StFlag: nb_q <= 3'd0;
      StCtr: begin
        x_q      <= prd;
        metric_q <= ard[15:0];
        sum_q    <= 35'sd0;
      end
      StNb: begin
        // Data of the previous request lands this cycle.
        if (nb_q != 3'd0) sum_q <= sum_q + 35'(signed'(prd));
        nb_q <= nb_q + 3'd1;
      end
      StMul1: t_q <= tsat;
      StMul2: begin
        nv_q <= sat32(64'(nsum));
      end
      StWb: if (chg > maxchg_q) maxchg_q <= chg;
      StNext: begin
        if (b_q == wl) begin
          b_q <= 8'd0;
          if (a_q == hl) begin
            a_q <= 8'd0;
            iter_cnt_q <= iter_cnt_q + 16'd1;
            if (!last_iter) maxchg_q <= 32'd0;
          end else begin
            a_q <= a_q + 8'd1;
          end
        end else begin
          b_q <= b_q + 8'd1;
        end
      end
      StResp: begin
        done_op_q    <= op_q;
        read_value_q <= (op_q == OpRead) ? prd : 32'd0;
        max_update_q <= (op_q == OpRun && iter_q != 16'd0) ? maxchg_q : 32'd0;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign done_op_o    = done_op_q;
  assign read_value_o = read_value_q;
  assign max_update_o = max_update_q;

  `MPHR_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, !in_ready_o)
  `MPHR_ASSERT_NEXT(a_resp_valid, clk_i, rst_ni, state_q == StResp, out_valid_o)
  `MPHR_ASSERT_IMP(a_wb_hole_only, clk_i, rst_ni, state_q == StWb, nb_q == 3'd5)
endmodule

>>> hw/rtl/mphr_pixel_ram.sv
module mphr_pixel_ram import mphr_pkg::*; (
  input  logic        clk_i,
  input  pix_req_t    req_i,
  output logic [31:0] rdata_o
);
  logic [31:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end
endmodule

>>> hw/rtl/mphr_attr_ram.sv
module mphr_attr_ram import mphr_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [16:0]      wdata_i,
  output logic [16:0]      rdata_o
);
  // Hold metric in the low 16 bits and the hole flag on top.
  logic [16:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> test/tb_metric_poisson_hole_relaxation.sv
module tb_metric_poisson_hole_relaxation import mphr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Side  = 256;
  localparam int unsigned Depth = Side * Side;

  // One expected result beat.
  typedef struct {
    op_e         op;
    logic [31:0] value;
    logic [31:0] change;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic [7:0]  col_i = '0;
  logic [7:0]  row_i = '0;
  logic signed [31:0] data_value_i = '0;
  logic        is_hole_i = 1'b0;
  logic [15:0] metric_value_i = '0;
  logic signed [31:0] init_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  done_op_o;
  logic signed [31:0] read_value_o;
  logic [31:0] max_update_o;

  metric_poisson_hole_relaxation i_dut (.*);

  // Shadow image: values, metrics, hole flags and which entries hold data.
  logic signed [31:0] pix_shadow [Depth];
  logic [15:0]        metric_shadow [Depth];
  bit                 hole_shadow [Depth];
  bit                 written [Depth];
  int unsigned        written_q [$];

  // Shadow of the configuration registers.
  logic [8:0]  width_reg  = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic [15:0] step_reg   = 16'd16384;
  logic [15:0] iter_reg   = 16'd100;

  result_t     pending_results [$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  bit          calm = 1'b0;   // when set, neither side idles

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Safety net: a hung block ends the run here.
  initial begin
    #40_000_000;
    $display("metric_poisson_hole_relaxation regression: fail");
    $finish;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 28);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic int unsigned active_dim(input logic [8:0] v);
    if (v == 0) return 1;
    return (v > Side) ? Side : 32'(v);
  endfunction

  // Relax the hole pixels in place for one sweep; return its largest change.
  function automatic logic [31:0] relax_sweep(input int unsigned w, input int unsigned h,
                                              input int unsigned order);
    bit rx, ry;
    int unsigned r, c, rn, rs, cw, ce, idx;
    longint x, lap, t, d, nv, diff;
    logic [31:0] worst, chg;
    rx = (order == 1 || order == 2);
    ry = (order == 1 || order == 3);
    worst = '0;
    for (int unsigned a = 0; a < h; a++) begin
      r  = ry ? h - 1 - a : a;
      rn = (r > 0) ? r - 1 : 0;
      rs = (r + 1 < h) ? r + 1 : h - 1;
      for (int unsigned b = 0; b < w; b++) begin
        c   = rx ? w - 1 - b : b;
        idx = r * Side + c;
        if (!hole_shadow[idx]) continue;
        cw  = (c > 0) ? c - 1 : 0;
        ce  = (c + 1 < w) ? c + 1 : w - 1;
        x   = longint'(pix_shadow[idx]);
        lap = longint'(pix_shadow[r * Side + ce]) + longint'(pix_shadow[rs * Side + c])
            + longint'(pix_shadow[r * Side + cw]) + longint'(pix_shadow[rn * Side + c])
            - 4 * x;
        t   = longint'(clip32((longint'(metric_shadow[idx]) * lap) >>> 8));
        d   = (longint'(step_reg) * t) >>> 16;
        nv  = longint'(clip32(x + d));
        diff = nv - x;
        chg = (diff < 0) ? 32'(-diff) : 32'(diff);
        if (chg > worst) worst = chg;
        pix_shadow[idx] = nv[31:0];
      end
    end
    return worst;
  endfunction

  // Work out the result of one accepted command beat and update the shadow.
  function automatic result_t predict_beat(input op_e op, input logic [7:0] c,
                                           input logic [7:0] r,
                                           input logic signed [31:0] dv, input bit hl,
                                           input logic [15:0] mv,
                                           input logic signed [31:0] iv);
    result_t res;
    int unsigned idx;
    idx = r * Side + c;
    res.op = op;
    res.value = '0;
    res.change = '0;
    case (op)
      OpWrite: begin
        pix_shadow[idx]    = hl ? iv : dv;
        metric_shadow[idx] = mv;
        hole_shadow[idx]   = hl;
        if (!written[idx]) written_q.push_back(idx);
        written[idx] = 1'b1;
      end
      OpRun: begin
        for (int unsigned k = 0; k < iter_reg; k++)
          res.change = relax_sweep(active_dim(width_reg), active_dim(height_reg), k % 4);
      end
      OpRead: res.value = pix_shadow[idx];
      default: ;
    endcase
    return res;
  endfunction

  // Send one command beat; idle at random first.
  task automatic send_beat(input op_e op, input logic [7:0] c, input logic [7:0] r,
                           input logic signed [31:0] dv, input bit hl,
                           input logic [15:0] mv, input logic signed [31:0] iv);
    @(negedge clk_i);
    while (idle_now()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    op_i = op;
    col_i = c;
    row_i = r;
    data_value_i = dv;
    is_hole_i = hl;
    metric_value_i = mv;
    init_value_i = iv;
    in_valid_i = 1'b1;
    // Hold the beat until the block takes it.
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_beat(op, c, r, dv, hl, mv, iv));
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Write one register over the APB port while the block is idle.
  task automatic set_reg(input reg_e which, input logic [31:0] v);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {which, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (which)
      RegWidth:  width_reg  = v[8:0];
      RegHeight: height_reg = v[8:0];
      RegStep:   step_reg   = v[15:0];
      default:   iter_reg   = v[15:0];
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Mostly moderate values so relaxation moves, sometimes the extremes.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(2097152)) - 32'sd1048576;
    endcase
  endfunction

  function automatic logic [15:0] pick_metric();
    case ($urandom_range(5))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(512));
    endcase
  endfunction

  task automatic write_random(input logic [7:0] c, input logic [7:0] r);
    send_beat(OpWrite, c, r, pick_value(), 1'($urandom_range(1)), pick_metric(),
              pick_value());
  endtask

  task automatic read_written();
    int unsigned idx;
    idx = written_q[$urandom_range(written_q.size() - 1)];
    send_beat(OpRead, 8'(idx % Side), 8'(idx / Side), $urandom, 1'($urandom_range(1)),
              16'($urandom), $urandom);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Check each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(done_op_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (done_op_o !== want.op)
          report_mismatch("done_op", 32'(done_op_o), 32'(want.op));
        if (read_value_o !== want.value) report_mismatch("read_value", read_value_o, want.value);
        if (max_update_o !== want.change)
          report_mismatch("max_update", max_update_o, want.change);
      end
    end
  end

  // Result side: stall at random unless a calm stretch is on.
  always @(negedge clk_i) begin
    out_ready_i = rst_ni && !idle_now();
  end

  // Small image with every operation, the field extremes and the scan orders.
  task automatic test_directed();
    set_reg(RegWidth, 32'd2);
    set_reg(RegHeight, 32'd2);
    send_beat(OpWrite, 8'd0, 8'd0, 32'sd0, 1'b1, 16'hffff, 32'sh7fff_ffff);
    send_beat(OpWrite, 8'd1, 8'd0, 32'sh8000_0000, 1'b0, 16'h0000, 32'sh7fff_ffff);
    send_beat(OpWrite, 8'd0, 8'd1, 32'sh7fff_ffff, 1'b1, 16'h0100, 32'sh8000_0000);
    send_beat(OpWrite, 8'd1, 8'd1, 32'sh7fff_ffff, 1'b0, 16'hffff, 32'sd0);
    send_beat(OpWrite, 8'd255, 8'd255, 32'sh1234_5678, 1'b0, 16'h8000, 32'sd0);
    send_beat(OpRead, 8'd255, 8'd255, 32'sd0, 1'b0, 16'h0, 32'sd0);
    send_beat(OpNone, 8'd17, 8'd3, 32'sd5, 1'b1, 16'h5, 32'sd5);
    set_reg(RegIter, 32'd0);
    send_beat(OpRun, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    set_reg(RegIter, 32'd4);
    send_beat(OpRun, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    set_reg(RegStep, 32'd65535);
    send_beat(OpRun, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    set_reg(RegStep, 32'd0);
    send_beat(OpRun, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    for (int i = 0; i < 4; i++)
      send_beat(OpRead, 8'(i % 2), 8'(i / 2), 32'sd0, 1'b0, 16'h0, 32'sd0);
  endtask

  // Oversized width saturates to the full row.
  task automatic test_wide_row();
    set_reg(RegWidth, 32'd511);
    set_reg(RegHeight, 32'd1);
    set_reg(RegStep, 32'd40000);
    set_reg(RegIter, 32'd3);
    for (int c = 0; c < Side; c++) write_random(8'(c), 8'd0);
    send_beat(OpRun, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    repeat (6) read_written();
  endtask

  // Zero width saturates to one column; full height.
  task automatic test_tall_column();
    set_reg(RegWidth, 32'd0);
    set_reg(RegHeight, 32'd256);
    set_reg(RegIter, 32'd2);
    for (int r = 0; r < Side; r++) write_random(8'd0, 8'(r));
    send_beat(OpRun, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    repeat (6) read_written();
  endtask

  // Largest sweep count on a single known pixel; no idling meanwhile.
  task automatic test_long_run();
    calm = 1'b1;
    set_reg(RegWidth, 32'd1);
    set_reg(RegHeight, 32'd1);
    set_reg(RegIter, 32'd65535);
    send_beat(OpWrite, 8'd0, 8'd0, 32'sd77, 1'b0, 16'h0100, 32'sd0);
    send_beat(OpRun, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    send_beat(OpRead, 8'd0, 8'd0, 32'sd0, 1'b0, 16'h0, 32'sd0);
    wait_drained();
    calm = 1'b0;
  endtask

  // Phases of random small images: fill the active area, then mix commands.
  task automatic test_random();
    int unsigned w, h, phase, pick;
    phase = 0;
    while (beats_sent < 1100) begin
      calm = (phase == 3);
      w = $urandom_range(6, 1);
      h = $urandom_range(6, 1);
      set_reg(RegWidth, w);
      set_reg(RegHeight, h);
      case ($urandom_range(3))
        0: set_reg(RegStep, 32'd65535);
        1: set_reg(RegStep, 32'd0);
        default: set_reg(RegStep, $urandom_range(65535));
      endcase
      set_reg(RegIter, $urandom_range(8));
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++) write_random(8'(c), 8'(r));
      repeat ($urandom_range(40, 20)) begin
        pick = $urandom_range(99);
        if (pick < 18) begin
          send_beat(OpRun, 8'($urandom), 8'($urandom), $urandom, 1'($urandom_range(1)),
                    16'($urandom), $urandom);
        end else if (pick < 40) begin
          write_random(8'($urandom_range(w - 1)), 8'($urandom_range(h - 1)));
        end else if (pick < 50) begin
          write_random(8'($urandom), 8'($urandom));
        end else if (pick < 94) begin
          read_written();
        end else begin
          send_beat(OpNone, 8'($urandom), 8'($urandom), $urandom, 1'($urandom_range(1)),
                    16'($urandom), $urandom);
        end
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_wide_row();
    test_tall_column();
    test_long_run();
    test_random();
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("metric_poisson_hole_relaxation regression: pass");
    end else begin
      $display("metric_poisson_hole_relaxation regression: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mphr_pkg.sv
hw/rtl/mphr_pixel_ram.sv
hw/rtl/mphr_attr_ram.sv
hw/rtl/metric_poisson_hole_relaxation.sv
test/tb_metric_poisson_hole_relaxation.sv
